FILE: hw/rtl/fresnel_dielectric_reflectance_unit_defines.svh
// ============================================================================
// Assertion macros for the Fresnel reflectance unit
// Shorthands for clocked implication checks that are disabled during reset.
// ============================================================================
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/fdr_pkg.sv
// ============================================================================
// Fresnel reflectance package
// Shared widths, constants and the sideband record carried down the pipeline.
// ============================================================================
`default_nettype none

package fdr_pkg;

    localparam int COS_W   = 16;
    localparam int RATIO_W = 15;
    localparam int T2_W    = 31;
    localparam int ROOT_W  = 16;
    localparam int AMP_W   = 30;
    localparam int QUO_W   = 31;

    localparam logic [RATIO_W-1:0] RATIO_MIN = 15'd1024;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 15'd16384;
    localparam logic [RATIO_W-1:0] ONE_Q12   = 15'd4096;
    localparam logic [COS_W-1:0]   ONE_Q15   = 16'd32768;

    // Per-item values that ride alongside the arithmetic.
    typedef struct packed {
        logic               outside;
        logic               matched;
        logic [COS_W-1:0]   ci;
        logic [RATIO_W-1:0] eta_it;
        logic [RATIO_W-1:0] eta_ti;
        logic [ROOT_W-1:0]  ct;
    } t_side;

endpackage

`default_nettype wire

FILE: hw/rtl/fdr_recip.sv
// ============================================================================
// Reciprocal ratio divider
// Pipelined restoring division giving round-half-up(2^24 / den), one bit a stage.
// ============================================================================
`default_nettype none

module fdr_recip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [fdr_pkg::RATIO_W-1:0]   i_den,
    input  fdr_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [fdr_pkg::RATIO_W-1:0]   o_quo,
    output fdr_pkg::t_side                o_side
);
    import fdr_pkg::*;

    localparam int N = RATIO_W;

    logic [24:0] w_num;

    logic               r_vld  [N];
    logic [RATIO_W-1:0] r_rem  [N];
    logic [RATIO_W-1:0] r_quo  [N];
    logic [RATIO_W-1:0] r_low  [N];
    logic [RATIO_W-1:0] r_den  [N];
    t_side              r_side [N];

    // Adding half the divisor makes the truncating quotient round half up.
    assign w_num = {1'b1, 24'd0} + {11'd0, i_den[RATIO_W-1:1]};

    for (genvar k = 0; k < N; k++) begin : g_st
        logic               p_vld;
        logic [RATIO_W-1:0] p_rem;
        logic [RATIO_W-1:0] p_quo;
        logic [RATIO_W-1:0] p_low;
        logic [RATIO_W-1:0] p_den;
        t_side              p_side;
        logic [RATIO_W:0]   w_sh;
        logic [RATIO_W:0]   w_diff;
        logic               w_ge;

        if (k == 0) begin : g_first
            // The top ten dividend bits are below any allowed divisor.
            assign p_vld  = i_valid;
            assign p_rem  = {5'd0, w_num[24:15]};
            assign p_quo  = '0;
            assign p_low  = w_num[14:0];
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_low  = r_low[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        assign w_sh   = {p_rem, p_low[RATIO_W-1]};
        assign w_diff = w_sh - {1'b0, p_den};
        assign w_ge   = (w_sh >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[RATIO_W-1:0] : w_sh[RATIO_W-1:0];
            r_quo[k]  <= {p_quo[RATIO_W-2:0], w_ge};
            r_low[k]  <= {p_low[RATIO_W-2:0], 1'b0};
            r_den[k]  <= p_den;
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/fdr_isqrt.sv
// ============================================================================
// Integer square root
// Pipelined digit-by-digit floor square root, one result bit per stage.
// ============================================================================
`default_nettype none

module fdr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fdr_pkg::T2_W-1:0]     i_val,
    input  fdr_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [fdr_pkg::ROOT_W-1:0]   o_root,
    output fdr_pkg::t_side               o_side
);
    import fdr_pkg::*;

    localparam int N     = ROOT_W;
    localparam int V_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              r_vld  [N];
    logic [REM_W-1:0]  r_rem  [N];
    logic [ROOT_W-1:0] r_root [N];
    logic [V_W-1:0]    r_low  [N];
    t_side             r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_st
        logic              p_vld;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [V_W-1:0]    p_low;
        t_side             p_side;
        logic [REM_W+1:0]  w_sh;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_low  = {{(V_W-T2_W){1'b0}}, i_val};
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_low  = r_low[k-1];
            assign p_side = r_side[k-1];
        end

        // The remainder stays at most twice the partial root.
        assign w_sh    = {p_rem, p_low[V_W-1:V_W-2]};
        assign w_trial = {2'b00, p_root, 2'b01};
        assign w_diff  = w_sh - w_trial;
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[REM_W-1:0] : w_sh[REM_W-1:0];
            r_root[k] <= {p_root[ROOT_W-2:0], w_ge};
            r_low[k]  <= {p_low[V_W-3:0], 2'b00};
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/fdr_ampdiv.sv
// ============================================================================
// Amplitude ratio divider
// Two-lane pipelined restoring division, floor(num * 2^30 / den), num <= den.
// ============================================================================
`default_nettype none

module fdr_ampdiv (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [1:0][fdr_pkg::AMP_W-1:0]     i_num,
    input  logic [1:0][fdr_pkg::AMP_W-1:0]     i_den,
    input  fdr_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [1:0][fdr_pkg::QUO_W-1:0]     o_quo,
    output fdr_pkg::t_side                     o_side
);
    import fdr_pkg::*;

    localparam int N = QUO_W;

    logic                        r_vld  [N];
    logic [1:0][AMP_W-1:0]       r_rem  [N];
    logic [1:0][QUO_W-1:0]       r_quo  [N];
    logic [1:0][AMP_W-1:0]       r_den  [N];
    t_side                       r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_st
        logic                  p_vld;
        logic [1:0][AMP_W-1:0] p_rem;
        logic [1:0][QUO_W-1:0] p_quo;
        logic [1:0][AMP_W-1:0] p_den;
        t_side                 p_side;
        logic [1:0][AMP_W-1:0] n_rem;
        logic [1:0][QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = i_num;
            assign p_quo  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        // The first step weighs the unshifted numerator for the integer bit.
        always_comb begin
            logic [AMP_W:0] v_sh;
            logic [AMP_W:0] v_diff;
            logic           v_ge;
            for (int l = 0; l < 2; l++) begin
                v_sh     = (k == 0) ? {1'b0, p_rem[l]} : {p_rem[l], 1'b0};
                v_diff   = v_sh - {1'b0, p_den[l]};
                v_ge     = (v_sh >= {1'b0, p_den[l]});
                n_rem[l] = v_ge ? v_diff[AMP_W-1:0] : v_sh[AMP_W-1:0];
                n_quo[l] = {p_quo[l][QUO_W-2:0], v_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_den[k]  <= p_den;
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/fresnel_dielectric_reflectance_unit.sv
// ============================================================================
// Fresnel dielectric reflectance unit
// Unpolarized reflectance, transmitted cosine and index ratios, fully pipelined.
// ============================================================================
// The unit accepts one item in every clock cycle: o_busy is always low, so an
// item is taken whenever i_start is high. Each item passes 71 register stages:
// its result is on the outputs as a one-cycle pulse on o_valid, with all four
// result fields. Results appear in the order the items went in and must be
// captured in that cycle, since the unit has no way to hold them. The stages
// come from three bit-per-stage units in series: a 15-stage reciprocal
// divider for the index ratio, a 16-stage square root for the transmitted
// cosine and a 31-stage two-lane divider for the s and p amplitude ratios,
// plus nine stages of input capture, multiplies and output formatting. The
// index ratio is clamped to 0.25..4.0 first; matched indices give reflectance
// zero, grazing incidence and total internal reflection give one.
// ============================================================================
`default_nettype none

`include "fresnel_dielectric_reflectance_unit_defines.svh"

module fresnel_dielectric_reflectance_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [fdr_pkg::COS_W-1:0]   i_cos_incident,
    input  logic [fdr_pkg::RATIO_W-1:0]        i_index_ratio,
    output logic                               o_valid,
    output logic [fdr_pkg::COS_W-1:0]          o_reflectance,
    output logic signed [fdr_pkg::COS_W-1:0]   o_cos_transmitted,
    output logic [fdr_pkg::RATIO_W-1:0]        o_ratio_incident_transmitted,
    output logic [fdr_pkg::RATIO_W-1:0]        o_ratio_transmitted_incident
);
    import fdr_pkg::*;

    // The pipeline never stalls, so the unit is always ready.
    assign o_busy = 1'b0;

    // ---------------------------------------------------------------- input
    // Clamp the ratio, take the magnitude of the cosine and flag the side.
    logic [COS_W-1:0]   w_raw;
    logic [COS_W-1:0]   w_ci;
    logic [RATIO_W-1:0] w_e;
    t_side              n_s0_side;

    logic               r_s0_vld;
    logic [RATIO_W-1:0] r_s0_e;
    t_side              r_s0_side;

    assign w_raw = i_cos_incident;
    assign w_ci  = w_raw[COS_W-1] ? (~w_raw + 16'd1) : w_raw;

    always_comb begin
        if (i_index_ratio < RATIO_MIN) begin
            w_e = RATIO_MIN;
        end else if (i_index_ratio > RATIO_MAX) begin
            w_e = RATIO_MAX;
        end else begin
            w_e = i_index_ratio;
        end
        n_s0_side         = '0;
        n_s0_side.outside = !w_raw[COS_W-1];
        n_s0_side.matched = (w_e == ONE_Q12);
        n_s0_side.ci      = w_ci;
        n_s0_side.eta_it  = w_e;
        n_s0_side.eta_ti  = w_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_e    <= w_e;
        r_s0_side <= n_s0_side;
    end

    // ----------------------------------------------------------- reciprocal
    logic               w_rc_vld;
    logic [RATIO_W-1:0] w_rc_quo;
    t_side              w_rc_side;

    fdr_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .i_den   (r_s0_e),
        .i_side  (r_s0_side),
        .o_valid (w_rc_vld),
        .o_quo   (w_rc_quo),
        .o_side  (w_rc_side)
    );

    // ------------------------------------------ stage A: pick ratios, c*c
    // The clamped ratio still sits in both eta fields of the sideband.
    logic [RATIO_W-1:0] w_rcp;
    t_side              n_a_side;
    logic [31:0]        w_ci2;

    logic               r_a_vld;
    logic [31:0]        r_a_ci2;
    t_side              r_a_side;

    always_comb begin
        if (w_rc_quo > RATIO_MAX) begin
            w_rcp = RATIO_MAX;
        end else if (w_rc_quo < RATIO_MIN) begin
            w_rcp = RATIO_MIN;
        end else begin
            w_rcp = w_rc_quo;
        end
        n_a_side        = w_rc_side;
        n_a_side.eta_it = w_rc_side.outside ? w_rc_side.eta_it : w_rcp;
        n_a_side.eta_ti = w_rc_side.outside ? w_rcp : w_rc_side.eta_ti;
    end

    assign w_ci2 = {16'd0, w_rc_side.ci} * {16'd0, w_rc_side.ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_rc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ci2  <= w_ci2;
        r_a_side <= n_a_side;
    end

    // ------------------------------------- stage B: sin^2 and ratio squared
    logic [29:0] w_eta2;
    logic [31:0] w_sin2;

    logic        r_b_vld;
    logic [30:0] r_b_sin2;
    logic [28:0] r_b_eta2;
    t_side       r_b_side;

    assign w_eta2 = {15'd0, r_a_side.eta_ti} * {15'd0, r_a_side.eta_ti};
    assign w_sin2 = {2'b01, 30'd0} - r_a_ci2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sin2 <= w_sin2[30:0];
        r_b_eta2 <= w_eta2[28:0];
        r_b_side <= r_a_side;
    end

    // ------------------------------------------ stage C: Snell product
    logic [59:0] w_prod;

    logic        r_c_vld;
    logic [58:0] r_c_prod;
    t_side       r_c_side;

    assign w_prod = {29'd0, r_b_sin2} * {31'd0, r_b_eta2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_prod <= w_prod[58:0];
        r_c_side <= r_b_side;
    end

    // ---------------------------- stage D: cos^2 of transmitted, clamped
    // A product at or above one means total internal reflection.
    logic [58:0]     w_t2_full;

    logic            r_d_vld;
    logic [T2_W-1:0] r_d_t2;
    t_side           r_d_side;

    assign w_t2_full = {4'd0, 1'b1, 54'd0} - r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_t2   <= (r_c_prod[58:54] != 5'd0) ? '0 : w_t2_full[54:24];
        r_d_side <= r_c_side;
    end

    // ---------------------------------------------------------- square root
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_sq_root;
    t_side             w_sq_side;

    fdr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld),
        .i_val   (r_d_t2),
        .i_side  (r_d_side),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // ------------------------------------ stage E: amplitude terms in Q3.27
    logic [30:0] w_bs;
    logic [30:0] w_bp;
    t_side       n_e_side;

    logic             r_e_vld;
    logic [AMP_W-1:0] r_e_as;
    logic [AMP_W-1:0] r_e_bs;
    logic [AMP_W-1:0] r_e_ap;
    logic [AMP_W-1:0] r_e_bp;
    t_side            r_e_side;

    assign w_bs = {16'd0, w_sq_side.eta_it} * {15'd0, w_sq_root};
    assign w_bp = {16'd0, w_sq_side.eta_it} * {15'd0, w_sq_side.ci};

    always_comb begin
        n_e_side    = w_sq_side;
        n_e_side.ct = w_sq_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_as   <= {2'b00, w_sq_side.ci, 12'd0};
        r_e_bs   <= w_bs[AMP_W-1:0];
        r_e_ap   <= {2'b00, w_sq_root, 12'd0};
        r_e_bp   <= w_bp[AMP_W-1:0];
        r_e_side <= n_e_side;
    end

    // ------------------------------ stage F: |a - b| over a + b, s and p
    logic                  r_f_vld;
    logic [1:0][AMP_W-1:0] r_f_num;
    logic [1:0][AMP_W-1:0] r_f_den;
    t_side                 r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_num[0] <= (r_e_as >= r_e_bs) ? (r_e_as - r_e_bs) : (r_e_bs - r_e_as);
        r_f_den[0] <= r_e_as + r_e_bs;
        r_f_num[1] <= (r_e_ap >= r_e_bp) ? (r_e_ap - r_e_bp) : (r_e_bp - r_e_ap);
        r_f_den[1] <= r_e_ap + r_e_bp;
        r_f_side   <= r_e_side;
    end

    // ----------------------------------------------------- amplitude divide
    // With zero incidence cosine the divisors can be zero; that result is
    // replaced at the output, so the quotient does not matter there.
    logic                  w_dv_vld;
    logic [1:0][QUO_W-1:0] w_dv_quo;
    t_side                 w_dv_side;

    fdr_ampdiv u_ampdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_num   (r_f_num),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // ----------------------------------------------- stage G: square both
    logic [61:0] w_s2;
    logic [61:0] w_p2;

    logic        r_g_vld;
    logic [60:0] r_g_s2;
    logic [60:0] r_g_p2;
    t_side       r_g_side;

    assign w_s2 = {31'd0, w_dv_quo[0]} * {31'd0, w_dv_quo[0]};
    assign w_p2 = {31'd0, w_dv_quo[1]} * {31'd0, w_dv_quo[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_s2   <= w_s2[60:0];
        r_g_p2   <= w_p2[60:0];
        r_g_side <= w_dv_side;
    end

    // ------------------------------------------- stage H: format results
    // Halving the Q2.60 sum and rounding to Q1.15 is one shift by 46.
    logic [61:0]      w_sum;
    logic [COS_W-1:0] w_rr;
    logic [COS_W-1:0] n_refl;
    logic [COS_W-1:0] n_cts;

    logic               r_h_vld;
    logic [COS_W-1:0]   r_h_refl;
    logic [COS_W-1:0]   r_h_cts;
    logic [RATIO_W-1:0] r_h_eta_it;
    logic [RATIO_W-1:0] r_h_eta_ti;

    assign w_sum = {1'b0, r_g_s2} + {1'b0, r_g_p2} + {16'd0, 1'b1, 45'd0};
    assign w_rr  = w_sum[61:46];

    always_comb begin
        priority if (r_g_side.matched) begin
            n_refl = '0;
        end else if (r_g_side.ci == '0) begin
            n_refl = ONE_Q15;
        end else if (w_rr > ONE_Q15) begin
            n_refl = ONE_Q15;
        end else begin
            n_refl = w_rr;
        end
        // The transmitted ray leaves on the far side; +1.0 saturates.
        if (r_g_side.outside) begin
            n_cts = ~r_g_side.ct + 16'd1;
        end else if (r_g_side.ct[ROOT_W-1]) begin
            n_cts = 16'h7FFF;
        end else begin
            n_cts = r_g_side.ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_refl   <= n_refl;
        r_h_cts    <= n_cts;
        r_h_eta_it <= r_g_side.eta_it;
        r_h_eta_ti <= r_g_side.eta_ti;
    end

    assign o_valid                      = r_h_vld;
    assign o_reflectance                = r_h_refl;
    assign o_cos_transmitted            = r_h_cts;
    assign o_ratio_incident_transmitted = r_h_eta_it;
    assign o_ratio_transmitted_incident = r_h_eta_ti;

    // ----------------------------------------------------------- checks
    `FDR_ASSERT_IMP(a_matched_zero,
        o_valid && (o_ratio_incident_transmitted == ONE_Q12), o_reflectance == '0,
        "matched indices must give zero reflectance")
    `FDR_ASSERT_IMP(a_refl_range, o_valid, o_reflectance <= ONE_Q15,
        "reflectance above one")
    `FDR_ASSERT_IMP(a_no_transmission,
        o_valid && (o_cos_transmitted == '0) && (o_ratio_incident_transmitted != ONE_Q12),
        o_reflectance == ONE_Q15,
        "zero transmitted cosine must give full reflection")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Fresnel reflectance unit testbench
// Drives directed and random incident cosines and index ratios, predicts the
// reflectance, transmitted cosine and both ratios, and compares in order.
// ============================================================================
`default_nettype none

module tb;

    import fdr_pkg::*;

    // One incident item as it goes into the unit.
    typedef struct packed {
        logic signed [COS_W-1:0] cos_i;
        logic [RATIO_W-1:0]      ratio;
    } t_ray;

    // One result item as it comes out of the unit.
    typedef struct packed {
        logic [COS_W-1:0]        refl;
        logic signed [COS_W-1:0] cos_t;
        logic [RATIO_W-1:0]      eta_it;
        logic [RATIO_W-1:0]      eta_ti;
    } t_bounce;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic signed [COS_W-1:0]   i_cos_incident;
    logic [RATIO_W-1:0]        i_index_ratio;
    logic                      o_valid;
    logic [COS_W-1:0]          o_reflectance;
    logic signed [COS_W-1:0]   o_cos_transmitted;
    logic [RATIO_W-1:0]        o_ratio_incident_transmitted;
    logic [RATIO_W-1:0]        o_ratio_transmitted_incident;

    fresnel_dielectric_reflectance_unit i_dut (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .i_start                      (i_start),
        .o_busy                       (o_busy),
        .i_cos_incident               (i_cos_incident),
        .i_index_ratio                (i_index_ratio),
        .o_valid                      (o_valid),
        .o_reflectance                (o_reflectance),
        .o_cos_transmitted            (o_cos_transmitted),
        .o_ratio_incident_transmitted (o_ratio_incident_transmitted),
        .o_ratio_transmitted_incident (o_ratio_transmitted_incident)
    );

    t_ray    pending_rays[$];
    t_bounce expected_bounces[$];
    int      mismatch_count;
    int      idle_percent;
    bit      all_queued;
    int      quiet_cycles;
    bit      in_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Integer square root, floor, by the classic bit-pair method.
    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] root;
        logic [31:0] bitpos;
        root = 0;
        bitpos = 32'h4000_0000;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Squared amplitude ratio |a-b|/(a+b) in Q2.60, quotient floored to Q1.30.
    function automatic logic [63:0] amplitude_sq(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] num;
        logic [63:0] quo;
        num = (a >= b) ? a - b : b - a;
        quo = (num << 30) / (a + b);
        return quo * quo;
    endfunction

    function automatic t_bounce predict_bounce(input t_ray ray);
        t_bounce     res;
        logic [31:0] eta;
        logic [31:0] rcp;
        logic [31:0] it;
        logic [31:0] ti;
        logic [31:0] ci;
        logic [31:0] ct;
        logic [63:0] sin2;
        logic [63:0] prod;
        logic [63:0] t2;
        logic [63:0] sum;
        logic [63:0] rr;
        logic        outside;
        outside = (ray.cos_i >= 0);
        eta = ray.ratio;
        if (eta < RATIO_MIN) eta = RATIO_MIN;
        if (eta > RATIO_MAX) eta = RATIO_MAX;
        rcp = ((32'd1 << 24) + (eta >> 1)) / eta;
        if (rcp > RATIO_MAX) rcp = RATIO_MAX;
        if (rcp < RATIO_MIN) rcp = RATIO_MIN;
        it = outside ? eta : rcp;
        ti = outside ? rcp : eta;
        ci = outside ? 32'(ray.cos_i) : 32'(-32'(signed'(ray.cos_i)));
        sin2 = (64'd1 << 30) - 64'(ci) * 64'(ci);
        prod = sin2 * (64'(ti) * 64'(ti));
        t2 = (prod >= (64'd1 << 54)) ? 64'd0 : (((64'd1 << 54) - prod) >> 24);
        ct = floor_sqrt(t2[31:0]);
        // Matched indices win over grazing incidence.
        if (eta == ONE_Q12) begin
            res.refl = '0;
        end else if (ci == 0) begin
            res.refl = ONE_Q15;
        end else begin
            sum = amplitude_sq(64'(ci) << 12, 64'(it) * 64'(ct))
                + amplitude_sq(64'(ct) << 12, 64'(it) * 64'(ci));
            rr = (sum + (64'd1 << 45)) >> 46;
            res.refl = (rr > 64'd32768) ? ONE_Q15 : rr[15:0];
        end
        // A transmitted cosine of +1.0 saturates on the inside-out path.
        if (outside) res.cos_t = -ct[15:0];
        else res.cos_t = (ct > 32767) ? 16'sd32767 : ct[15:0];
        res.eta_it = it[RATIO_W-1:0];
        res.eta_ti = ti[RATIO_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic add_ray(input int c, input int e);
        t_ray ray;
        ray.cos_i = c[15:0];
        ray.ratio = e[14:0];
        pending_rays.push_back(ray);
    endtask

    // Driver: inputs change on the falling edge. Acceptance is sampled by the
    // monitor on the rising edge; an item that was not taken stays in place.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !in_taken) begin
                // hold the current item
            end else if (pending_rays.size() > 0 && $urandom_range(99) >= idle_percent) begin
                t_ray ray;
                ray = pending_rays.pop_front();
                i_cos_incident <= ray.cos_i;
                i_index_ratio  <= ray.ratio;
                i_start        <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: items and results are sampled on the rising edge they are
    // accepted at.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                expected_bounces.push_back(predict_bounce({i_cos_incident, i_index_ratio}));
            end
            if ((i_start && !o_busy) || o_valid) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (o_valid) begin
                if (expected_bounces.size() == 0) begin
                    report_mismatch("unexpected result", o_reflectance, -1);
                end else begin
                    t_bounce want;
                    want = expected_bounces.pop_front();
                    if (o_reflectance !== want.refl)
                        report_mismatch("reflectance", o_reflectance, want.refl);
                    if (o_cos_transmitted !== want.cos_t)
                        report_mismatch("cos_transmitted", o_cos_transmitted, want.cos_t);
                    if (o_ratio_incident_transmitted !== want.eta_it)
                        report_mismatch("ratio_incident_transmitted",
                                        o_ratio_incident_transmitted, want.eta_it);
                    if (o_ratio_transmitted_incident !== want.eta_ti)
                        report_mismatch("ratio_transmitted_incident",
                                        o_ratio_transmitted_incident, want.eta_ti);
                end
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int phase;
        int c;
        int e;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cos_incident = '0;
        i_index_ratio = '0;
        mismatch_count = 0;
        idle_percent = 0;
        all_queued = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, clamping, matched, grazing, internal reflection.
        add_ray(32767, 4096);
        add_ray(-32768, 4096);
        add_ray(0, 6000);
        add_ray(0, 4096);
        add_ray(32767, 1024);
        add_ray(-32768, 16384);
        add_ray(32767, 0);
        add_ray(-1, 32767);
        add_ray(1, 0);
        add_ray(-32768, 1023);
        add_ray(32767, 16385);
        add_ray(-20000, 6144);
        add_ray(3000, 2048);
        add_ray(-3000, 6144);
        add_ray(-100, 16384);
        add_ray(100, 1024);
        add_ray(32767, 6144);
        add_ray(-32767, 2048);
        add_ray(23170, 5461);
        add_ray(-1, 4095);
        add_ray(-1, 4097);

        // Random phases with varying sender idling.
        for (phase = 0; phase < 4; phase++) begin
            while (pending_rays.size() > 0) @(posedge i_clk);
            idle_percent = (phase == 1) ? 47 : (phase == 3) ? 32 : 0;
            repeat (257) begin
                c = $urandom_range(65535);
                case ($urandom_range(9))
                    0: e = $urandom_range(32767);
                    1: e = $urandom_range(1) ? 4096 : $urandom_range(1) ? 1024 : 16384;
                    default: e = $urandom_range(16384, 1024);
                endcase
                if ($urandom_range(15) == 0) c = $urandom_range(1) ? 0 : 32767;
                add_ray(c, e);
            end
        end
        while (pending_rays.size() > 0) @(posedge i_clk);
        all_queued = 1'b1;
        while (expected_bounces.size() > 0 || i_start) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bounces.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
